// ===== hw/rtl/linear_probe_hash_table_top_assert.svh =====
// assertion macros for the hash table block
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LPHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LPHT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define LPHT_ASSERT(label, clk, rst, prop, msg)

`define LPHT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

   localparam int DEF_SLOTS       = 128;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   // port field widths
   localparam int OP_BITS     = 2;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 3;
   localparam int TOTAL_BITS  = 8;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_FOUND   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_BADKEY  = 3'd4;

   // residue unit consumes this many key bits a cycle
   localparam int RES_DIGIT = 4;

   typedef struct packed {
      logic clear;
      logic load_key;
      logic load_value;
      logic erase;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/lpht_if.sv =====
interface lpht_req_if;
   import lpht_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    op;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink (input valid, input op, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
   import lpht_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [VALUE_BITS-1:0]  value_out;
   logic [TOTAL_BITS-1:0]  entry_total;

   modport source (output valid, output status, output value_out, output entry_total,
                   input ready);
   modport sink (input valid, input status, input value_out, input entry_total,
                 output ready);
endinterface

// ===== hw/rtl/lpht_cell.sv =====
module lpht_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int SLOT_BITS   = 7,
   parameter int INDEX       = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmp_en,
   input  logic [KEY_WIDTH-1:0]     cmp_key,
   input  logic [SLOT_BITS-1:0]     home,
   input  lpht_pkg::cell_cmd_type   cmd,
   input  logic [KEY_WIDTH-1:0]     wr_key,
   input  logic [VALUE_WIDTH-1:0]   wr_value,
   output logic                     match,
   output logic                     free,
   output logic [VALUE_WIDTH-1:0]   hit_value
);
   import lpht_pkg::*;

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   match_ff, match_in;
   logic                   empty_ff, empty_in;

   always_comb begin
      priority if (cmd.clear || cmd.erase) begin
         key_in = '0;
      end else if (cmd.load_key) begin
         key_in = wr_key;
      end else begin
         key_in = key_ff;
      end
      // compare flags are taken at request acceptance and hold until the next one
      match_in = cmp_en ? (key_ff == cmp_key) : match_ff;
      empty_in = cmp_en ? (key_ff == '0) : empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         match_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         match_ff <= match_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_value) begin
         value_ff <= wr_value;
      end
   end

   assign match     = match_ff;
   assign free      = empty_ff && (SLOT_BITS'(INDEX) >= home);
   assign hit_value = match_ff ? value_ff : '0;

endmodule

// ===== hw/rtl/lpht_residue.sv =====
module lpht_residue #(
   parameter int KEY_WIDTH = 32,
   parameter int SLOTS     = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_WIDTH-1:0]       key,
   output logic [$clog2(SLOTS)-1:0]   home,
   output logic                       done
);
   import lpht_pkg::*;

   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam bit IS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
   localparam int STEPS     = (KEY_WIDTH + RES_DIGIT - 1) / RES_DIGIT;
   localparam int PAD       = STEPS * RES_DIGIT;
   localparam int STEP_BITS = $clog2(STEPS + 1);

   logic [STEP_BITS-1:0] steps_ff, steps_in;

   always_comb begin
      if (start) begin
         steps_in = IS_POW2 ? '0 : STEP_BITS'(STEPS);
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - 1'b1;
      end else begin
         steps_in = steps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
   end

   assign done = (steps_ff == '0);

   generate
      if (IS_POW2) begin : g_mask
         logic [SLOT_BITS-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (start) begin
               home_ff <= SLOT_BITS'(key);
            end
         end

         assign home = home_ff;
      end else begin : g_iter
         logic [PAD-1:0]       shift_ff;
         logic [SLOT_BITS-1:0] rem_ff, rem_in;

         // one key digit a cycle, most significant first, conditional subtract per bit
         always_comb begin
            logic [SLOT_BITS:0]   t;
            logic [SLOT_BITS-1:0] r;
            r = rem_ff;
            for (int j = 0; j < RES_DIGIT; j++) begin
               t = {r, shift_ff[PAD-1-j]};
               if (t >= (SLOT_BITS+1)'(SLOTS)) begin
                  t = t - (SLOT_BITS+1)'(SLOTS);
               end
               r = t[SLOT_BITS-1:0];
            end
            rem_in = r;
         end

         always_ff @(posedge clock) begin
            if (start) begin
               shift_ff <= PAD'(key);
               rem_ff   <= '0;
            end else if (steps_ff != '0) begin
               shift_ff <= shift_ff << RES_DIGIT;
               rem_ff   <= rem_in;
            end
         end

         assign home = rem_ff;
      end
   endgenerate

endmodule

// ===== hw/rtl/linear_probe_hash_table_top.sv =====
// Key/value table of SLOTS slots with linear probing upward from the home slot
// (key modulo SLOTS), no wrap. Key zero marks an empty slot and is rejected.
// req_ch carries op, key and value; rsp_ch returns status, value_out and
// entry_total, one response per request, in request order. Both are valid/ready.
// Every slot is a cell holding its key and value; all cells compare the request
// key in the cycle it is accepted. Once the home slot is known and any waiting
// response is being taken, the hit is picked up, or the first free cell at or
// above home is granted, and the response registered. The home slot comes from
// a residue unit, which masks the key when SLOTS is a power of two and otherwise
// does four key bits a cycle. A new request is accepted only once the previous
// one has had its update, as the cell row compares and then updates.
// A waiting response does not block the next accept; the update of that next
// request stalls only while the previous response is still not taken.
// Reset empties every slot and zeroes the count.
`include "linear_probe_hash_table_top_assert.svh"

module linear_probe_hash_table_top #(
   parameter int SLOTS       = lpht_pkg::DEF_SLOTS,
   parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   lpht_req_if.sink    req_ch,
   lpht_rsp_if.source  rsp_ch
);
   import lpht_pkg::*;

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = $clog2(SLOTS + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [OP_BITS-1:0]     op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [KEY_WIDTH-1:0]   req_key;

   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, status_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, value_out_in;
   logic [TOTAL_BITS-1:0]  rsp_total_ff;

   logic                 req_fire, go;
   logic [SLOT_BITS-1:0] home;
   logic                 home_done;

   logic [SLOTS-1:0]       match_vec, free_vec, grant_vec;
   logic [VALUE_WIDTH-1:0] cell_value [SLOTS];
   cell_cmd_type           cell_cmd [SLOTS];
   logic [VALUE_WIDTH-1:0] hit_value;
   logic                   hit, has_free, is_clear, bad_key, do_insert, do_remove;
   logic [63:0]            count_wide;

   assign req_key  = KEY_WIDTH'(req_ch.key);
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign go = (state_ff == S_EXEC) && home_done && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_ch.op;
         key_ff   <= req_key;
         value_ff <= VALUE_WIDTH'(req_ch.value);
      end
   end

   lpht_residue #(
      .KEY_WIDTH (KEY_WIDTH),
      .SLOTS     (SLOTS)
   ) u_residue (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .key   (req_key),
      .home  (home),
      .done  (home_done)
   );

   generate
      for (genvar g = 0; g < SLOTS; g++) begin : g_cell
         lpht_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .SLOT_BITS   (SLOT_BITS),
            .INDEX       (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmp_en    (req_fire),
            .cmp_key   (req_key),
            .home      (home),
            .cmd       (cell_cmd[g]),
            .wr_key    (key_ff),
            .wr_value  (value_ff),
            .match     (match_vec[g]),
            .free      (free_vec[g]),
            .hit_value (cell_value[g])
         );
      end
   endgenerate

   // lowest free cell at or above home
   assign grant_vec = free_vec & (~free_vec + SLOTS'(1));

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_value = hit_value | cell_value[i];
      end
   end

   always_comb begin
      hit       = |match_vec;
      has_free  = |free_vec;
      is_clear  = (op_ff == OP_CLEAR);
      bad_key   = !is_clear && (key_ff == '0);
      do_insert = (op_ff == OP_INSERT) && !bad_key;
      do_remove = (op_ff == OP_REMOVE) && !bad_key;

      for (int i = 0; i < SLOTS; i++) begin
         cell_cmd[i].clear      = go && is_clear;
         cell_cmd[i].load_key   = go && do_insert && !hit && grant_vec[i];
         cell_cmd[i].load_value = go && do_insert && (hit ? match_vec[i] : grant_vec[i]);
         cell_cmd[i].erase      = go && do_remove && match_vec[i];
      end

      count_in     = count_ff;
      value_out_in = '0;
      unique case (op_ff)
         OP_CLEAR: begin
            status_in = ST_FOUND;
            count_in  = '0;
         end
         OP_INSERT: begin
            priority if (bad_key) begin
               status_in = ST_BADKEY;
            end else if (hit) begin
               status_in = ST_FOUND;
            end else if (has_free) begin
               status_in = ST_ADDED;
               count_in  = count_ff + 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_REMOVE, OP_LOOKUP: begin
            priority if (bad_key) begin
               status_in = ST_BADKEY;
            end else if (hit) begin
               status_in    = ST_FOUND;
               value_out_in = VALUE_BITS'(hit_value);
               if (do_remove && count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               status_in = ST_MISSING;
            end
         end
         default: begin
            status_in = ST_BADKEY;
         end
      endcase

      count_wide = 64'(count_in);

      unique case (state_ff)
         S_IDLE:  state_in = req_fire ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = go ? S_IDLE : S_EXEC;
         default: state_in = S_IDLE;
      endcase

      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= value_out_in;
         rsp_total_ff  <= count_wide[TOTAL_BITS-1:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.value_out   = rsp_value_ff;
   assign rsp_ch.entry_total = rsp_total_ff;

   // a nonzero key lives in at most one slot
   `LPHT_ASSERT(a_unique_key, clock, reset, (state_ff == S_EXEC && key_ff != '0) |-> $onehot0(match_vec), "key stored in more than one slot")
   `LPHT_NEVER(a_count_range, clock, reset, count_ff > COUNT_BITS'(SLOTS), "entry count above slot count")
   `LPHT_ASSERT(a_added_count, clock, reset, (go && status_in == ST_ADDED) |=> (count_ff == COUNT_BITS'($past(count_ff) + 1'b1)), "count did not rise on new insert")
   `LPHT_NEVER(a_lost_response, clock, reset, go && rsp_valid_ff && !rsp_ch.ready, "response overwritten while stalled")

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpht_pkg::*;

   localparam int N_SLOTS = DEF_SLOTS;
   localparam int POOL_SIZE = 192;
   localparam int TAIL_ITEMS = 150;
   localparam int RANDOM_ITEMS = 1500;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic                  drain_first;
   } table_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [VALUE_BITS-1:0]  value_out;
      logic [TOTAL_BITS-1:0]  total;
   } table_answer_type;

   logic clock;
   logic reset;

   lpht_req_if req_ch ();
   lpht_rsp_if rsp_ch ();

   linear_probe_hash_table_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the table
   logic [KEY_BITS-1:0]   table_key [N_SLOTS];
   logic [VALUE_BITS-1:0] table_val [N_SLOTS];
   int                    table_count;

   table_req_type    pending_q [$];
   table_answer_type answer_q [$];
   table_req_type    cur_req;
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
   int item_total;
   int sent_count;
   int fail_count;
   int gap_left;
   int stall_left;

   function automatic table_answer_type table_apply(table_req_type r);
      table_answer_type a;
      int hit;
      int hole;
      int home;
      a.status = ST_FOUND;
      a.value_out = '0;
      hit = -1;
      hole = -1;
      home = int'(r.key % N_SLOTS);
      if (r.op == OP_CLEAR) begin
         for (int i = 0; i < N_SLOTS; i++) table_key[i] = '0;
         table_count = 0;
      end else if (r.key == '0) begin
         a.status = ST_BADKEY;
      end else begin
         // probe upward from home, no wrap
         for (int i = home; i < N_SLOTS; i++) begin
            if (hit < 0 && table_key[i] == r.key) hit = i;
            if (hole < 0 && table_key[i] == '0) hole = i;
         end
         if (r.op == OP_INSERT) begin
            if (hit >= 0) begin
               table_val[hit] = r.value;
               a.status = ST_FOUND;
            end else if (hole >= 0) begin
               table_key[hole] = r.key;
               table_val[hole] = r.value;
               table_count++;
               a.status = ST_ADDED;
            end else begin
               a.status = ST_FULL;
            end
         end else if (hit >= 0) begin
            a.value_out = table_val[hit];
            if (r.op == OP_REMOVE) begin
               table_key[hit] = '0;
               if (table_count > 0) table_count--;
            end
         end else begin
            a.status = ST_MISSING;
         end
      end
      a.total = table_count[TOTAL_BITS-1:0];
      return a;
   endfunction

   function automatic table_req_type make_request(logic [OP_BITS-1:0] op,
                                                  logic [KEY_BITS-1:0] key,
                                                  logic [VALUE_BITS-1:0] value,
                                                  logic drain_first = 1'b0);
      table_req_type r;
      r.op = op;
      r.key = key;
      r.value = value;
      r.drain_first = drain_first;
      return r;
   endfunction

   // zero key goes to insert, remove or lookup, picked by the roll modulo three
   function automatic logic [OP_BITS-1:0] OP_LOGIC_PICK(int roll);
      case (roll % 3)
         0: return OP_INSERT;
         1: return OP_REMOVE;
         default: return OP_LOOKUP;
      endcase
   endfunction

   // at least half of the keys land in the top slots so probe chains run off the end
   function automatic logic [KEY_BITS-1:0] fresh_key();
      logic [KEY_BITS-1:0] k;
      logic [6:0] home;
      if ($urandom_range(0, 1) == 0) home = 7'($urandom_range(112, 127));
      else home = 7'($urandom_range(0, 127));
      k = {$urandom} & ~32'h7f;
      k[6:0] = home;
      if (k == '0) k = 32'h80;
      return k;
   endfunction

   function automatic logic [VALUE_BITS-1:0] fresh_value();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            answer_q.push_back(table_apply(cur_req));
            sent_count++;
            if (pending_q.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 5);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && answer_q.size() != 0)) begin
               req_ch.valid <= 1'b0;
            end else begin
               cur_req = pending_q.pop_front();
               req_ch.op <= cur_req.op;
               req_ch.key <= cur_req.key;
               req_ch.value <= cur_req.value;
               req_ch.valid <= 1'b1;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: status=%0d value_out=%h total=%0d",
                           rsp_ch.status, rsp_ch.value_out, rsp_ch.entry_total);
            end else begin
               want = answer_q.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.value_out !== want.value_out ||
                   rsp_ch.entry_total !== want.total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: status exp %0d got %0d, ",
                               "value_out exp %h got %h, total exp %0d got %0d"},
                              want.status, rsp_ch.status, want.value_out, rsp_ch.value_out,
                              want.total, rsp_ch.entry_total);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (pending_q.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 5);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      table_req_type r;
      int pick;
      int roll;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_INSERT;
      req_ch.key = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      sent_count = 0;
      fail_count = 0;
      table_count = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
         table_key[i] = '0;
         table_val[i] = '0;
      end

      // zero key, update, top slot overflow, probing past a removed slot
      pending_q.push_back(make_request(OP_LOOKUP, 32'h0, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h0, 32'hffff_ffff));
      pending_q.push_back(make_request(OP_REMOVE, 32'h0, 32'h0));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h5, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h5, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h5, 32'hffff_ffff));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h5, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5));
      pending_q.push_back(make_request(OP_INSERT, 32'h7f, 32'h1));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h7f, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h17f, 32'h2));
      pending_q.push_back(make_request(OP_LOOKUP, 32'hffff_ffff, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h85, 32'h5a5a_5a5a));
      pending_q.push_back(make_request(OP_REMOVE, 32'h5, 32'h0));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h85, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678));
      pending_q.push_back(make_request(OP_REMOVE, 32'h5, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h7e, 32'h3));
      pending_q.push_back(make_request(OP_INSERT, 32'hfe, 32'h4));
      pending_q.push_back(make_request(OP_CLEAR, 32'hdead_beef, 32'hffff_ffff, 1'b1));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h85, 32'h0));
      pending_q.push_back(make_request(OP_LOOKUP, 32'h8000_0000, 32'h0));
      pending_q.push_back(make_request(OP_INSERT, 32'h1, 32'h1));
      pending_q.push_back(make_request(OP_REMOVE, 32'hffff_ffff, 32'h0));

      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = fresh_key();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 32) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
         pick = $urandom_range(0, POOL_SIZE - 1);
         roll = $urandom_range(0, 999);
         r = make_request(OP_INSERT, key_pool[pick], fresh_value(), n == RANDOM_ITEMS / 2);
         if (roll < 500) r.op = OP_INSERT;
         else if (roll < 720) r.op = OP_REMOVE;
         else if (roll < 960) r.op = OP_LOOKUP;
         else if (roll < 965) r.op = OP_CLEAR;
         else if (roll < 980) begin
            r.op = OP_LOGIC_PICK(roll);
            r.key = '0;
         end else begin
            r.op = OP_BITS'($urandom_range(0, 2));
            r.key = $urandom;
         end
         if (r.op == OP_CLEAR) begin
            r.key = $urandom;
            r.value = $urandom;
         end
         pending_q.push_back(r);
      end
      item_total = pending_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != item_total || answer_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && answer_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_if.sv
hw/rtl/lpht_cell.sv
hw/rtl/lpht_residue.sv
hw/rtl/linear_probe_hash_table_top.sv
tb/tb.sv
